>>> rtl/tlg_pkg.sv
// Shared types, codes and fixed constants of the turtle line generator.
`default_nettype none

package tlg_pkg;

  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int LEN_W   = 16;
  localparam int MAG_W   = 15;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;

  // Turtle actions.
  localparam logic [2:0] CMD_DRAW    = 3'd0;
  localparam logic [2:0] CMD_MOVE    = 3'd1;
  localparam logic [2:0] CMD_CCW     = 3'd2;
  localparam logic [2:0] CMD_CW      = 3'd3;
  localparam logic [2:0] CMD_SAVE    = 3'd4;
  localparam logic [2:0] CMD_RESTORE = 3'd5;
  localparam logic [2:0] CMD_STAY    = 3'd6;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FULL  = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_HEADING = 3'd4;

  // Register reset values.
  localparam logic [LEN_W-1:0]          STEP_LENGTH_RST    = 16'd5120;
  localparam logic [ANGLE_W-1:0]        TURN_STEP_RST      = 16'd16384;
  localparam logic signed [COORD_W-1:0] ORIGIN_X_RST       = 24'sd122880;
  localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST       = 24'sd184320;
  localparam logic [ANGLE_W-1:0]        ORIGIN_HEADING_RST = 16'd0;

  // Quarter-wave sine generation, Q30 Taylor series in Horner form.
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [4:0][7:0] TAYLOR_DIV = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110};

  typedef struct packed {
    logic [ANGLE_W-1:0]        heading;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pose_t;

  typedef struct packed {
    logic             sin_neg;
    logic [MAG_W-1:0] sin_mag;
    logic             cos_neg;
    logic [MAG_W-1:0] cos_mag;
  } trig_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stack_status_t;

endpackage

`default_nettype wire

>>> rtl/tlg_sine_rom.sv
// Quarter-wave sine table with registered sine and cosine reads of one angle.
`default_nettype none

module tlg_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic [tlg_pkg::ANGLE_W-1:0] angle,
  output tlg_pkg::trig_t              trig
);

  localparam int N = $clog2(SINE_TABLE_DEPTH);
  localparam logic [N:0] FULL_QUARTER = (N+1)'(SINE_TABLE_DEPTH);

  typedef logic [SINE_TABLE_DEPTH:0][tlg_pkg::MAG_W-1:0] qtab_t;

  // Entry i holds sin(pi/2 * i/DEPTH) in Q14, capped at one.
  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x  = (tlg_pkg::HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = tlg_pkg::Q30_ONE;
      for (int k = 0; k < 5; k++) begin
        t = tlg_pkg::Q30_ONE - (((x2 * t) >> 30) / 64'(tlg_pkg::TAYLOR_DIV[k]));
      end
      s = (x * t) >> 30;
      r = (s + 64'd32768) >> 16;
      if (r > 64'd16384) begin
        r = 64'd16384;
      end
      tab[i] = r[tlg_pkg::MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [N-1:0] idx;
  logic [1:0]   sin_quad;
  logic [1:0]   cos_quad;
  logic [N-1:0] rem;
  logic [N:0]   sin_addr;
  logic [N:0]   cos_addr;

  always_comb begin
    idx      = angle[tlg_pkg::ANGLE_W-1 -: N];
    sin_quad = idx[N-1 -: 2];
    cos_quad = sin_quad + 2'd1;
    rem      = {idx[N-3:0], 2'b00};
    sin_addr = sin_quad[0] ? FULL_QUARTER - {1'b0, rem} : {1'b0, rem};
    cos_addr = cos_quad[0] ? FULL_QUARTER - {1'b0, rem} : {1'b0, rem};
  end

  always_ff @(posedge clk) begin
    trig.sin_mag <= QTAB[sin_addr];
    trig.cos_mag <= QTAB[cos_addr];
    trig.sin_neg <= sin_quad[1];
    trig.cos_neg <= cos_quad[1];
  end

endmodule

`default_nettype wire

>>> rtl/tlg_step.sv
// One coordinate step: pen minus length times a signed Q14 factor, saturated.
`default_nettype none

module tlg_step (
  input  logic signed [tlg_pkg::COORD_W-1:0] pen,
  input  logic                               neg,
  input  logic [tlg_pkg::MAG_W-1:0]          mag,
  input  logic [tlg_pkg::LEN_W-1:0]          len,
  output logic signed [tlg_pkg::COORD_W-1:0] pen_next
);

  logic [30:0]        prod;
  logic [31:0]        rounded;
  logic [17:0]        delta;
  logic signed [25:0] wide;

  always_comb begin
    prod    = 31'(len) * 31'(mag);
    rounded = 32'(prod) + 32'd8192;
    delta   = rounded[31:14];
    // Moving against a negative factor adds the distance.
    if (neg) begin
      wide = 26'(pen) + $signed({8'b0, delta});
    end else begin
      wide = 26'(pen) - $signed({8'b0, delta});
    end
    if (wide > 26'sd8388607) begin
      pen_next = 24'sh7FFFFF;
    end else if (wide < -26'sd8388608) begin
      pen_next = 24'sh800000;
    end else begin
      pen_next = wide[23:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tlg_pose_stack.sv
// Save stack of poses in a memory, with the top entry always on hand.
`default_nettype none

module tlg_pose_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tlg_pkg::stack_ctrl_t   ctrl,
  input  tlg_pkg::pose_t         push_data,
  output tlg_pkg::pose_t         top,
  output tlg_pkg::stack_status_t status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  tlg_pkg::pose_t mem [STACK_DEPTH];
  tlg_pkg::pose_t rd_data;
  tlg_pkg::pose_t byp_data;
  logic           byp;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  top_slot;

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
    top_slot      = count_next - 1'b1;
    status.full   = (count == CW'(STACK_DEPTH));
    status.empty  = (count == '0);
    // A pose pushed last cycle is not yet visible at the memory output.
    top = byp ? byp_data : rd_data;
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count[AW-1:0]] <= push_data;
    end
    rd_data  <= mem[top_slot[AW-1:0]];
    byp_data <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      byp   <= 1'b0;
    end else begin
      count <= count_next;
      byp   <= ctrl.push;
    end
  end

endmodule

`default_nettype wire

>>> rtl/turtle_line_generator_unit.sv
// Top level of the turtle line generator: registers, turtle state and result stage.
//
//   Channel   Signals                            Direction  Moves
//   act       act_valid, act_stall, cmd, restart in         one turtle action request
//   seg       seg_valid, seg_stall, line_valid,  out        one result per action
//             from_x, from_y, to_x, to_y, fault
//   cfg       cfg_write, cfg_index, cfg_data     in         register write, no wait
//
// One request is taken per cycle while act_stall is low. Its result sits in the result
// register in the cycle after acceptance, computed by the single compute stage between
// turtle state and that register. Heading sine and cosine are read from a registered
// table addressed by the next heading, so they are ready for the very next request.
// act_stall is high only while a result is held and seg_stall is high.
// Reset (synchronous, active high) restores the register defaults, puts the pen at
// the origin and empties the save stack; there is no clearing pass.
`default_nettype none

module turtle_line_generator_unit #(
  parameter int STACK_DEPTH      = 64,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write,
  input  logic [tlg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tlg_pkg::CFG_W-1:0]            cfg_data,
  // Action requests.
  input  logic                                 act_valid,
  output logic                                 act_stall,
  input  logic [2:0]                           cmd,
  input  logic                                 restart,
  // Results.
  output logic                                 seg_valid,
  input  logic                                 seg_stall,
  output logic                                 line_valid,
  output logic signed [tlg_pkg::COORD_W-1:0]   from_x,
  output logic signed [tlg_pkg::COORD_W-1:0]   from_y,
  output logic signed [tlg_pkg::COORD_W-1:0]   to_x,
  output logic signed [tlg_pkg::COORD_W-1:0]   to_y,
  output logic [1:0]                           fault
);

  // Configuration registers.
  logic [tlg_pkg::LEN_W-1:0]          step_length;
  logic [tlg_pkg::ANGLE_W-1:0]        turn_step;
  logic signed [tlg_pkg::COORD_W-1:0] origin_x;
  logic signed [tlg_pkg::COORD_W-1:0] origin_y;
  logic [tlg_pkg::ANGLE_W-1:0]        origin_heading;
  logic [tlg_pkg::ANGLE_W-1:0]        origin_heading_next;

  // Turtle state.
  logic signed [tlg_pkg::COORD_W-1:0] pen_x;
  logic signed [tlg_pkg::COORD_W-1:0] pen_y;
  logic [tlg_pkg::ANGLE_W-1:0]        heading;
  logic signed [tlg_pkg::COORD_W-1:0] pen_x_next;
  logic signed [tlg_pkg::COORD_W-1:0] pen_y_next;
  logic [tlg_pkg::ANGLE_W-1:0]        heading_next;
  logic [tlg_pkg::ANGLE_W-1:0]        head_angle;

  // Pose after an optional restart, the one the action works on.
  logic signed [tlg_pkg::COORD_W-1:0] base_x;
  logic signed [tlg_pkg::COORD_W-1:0] base_y;
  logic [tlg_pkg::ANGLE_W-1:0]        base_heading;
  logic signed [tlg_pkg::COORD_W-1:0] step_x;
  logic signed [tlg_pkg::COORD_W-1:0] step_y;

  tlg_pkg::trig_t         head_trig;
  tlg_pkg::trig_t         org_trig;
  tlg_pkg::trig_t         trig;
  tlg_pkg::pose_t         top_pose;
  tlg_pkg::pose_t         push_pose;
  tlg_pkg::stack_ctrl_t   stack_ctrl;
  tlg_pkg::stack_status_t stack_status;

  logic       accept;
  logic       line_next;
  logic [1:0] fault_next;

  assign act_stall = seg_valid & seg_stall;
  assign accept    = act_valid & ~act_stall;

  // ---------------------------------------------------------------------------
  // Configuration registers. The origin heading has its own table read, so its
  // next value addresses that table and a restart can use it right away.
  // ---------------------------------------------------------------------------
  always_comb begin
    origin_heading_next = origin_heading;
    if (rst) begin
      origin_heading_next = tlg_pkg::ORIGIN_HEADING_RST;
    end else if (cfg_write && cfg_index == tlg_pkg::REG_ORIGIN_HEADING) begin
      origin_heading_next = cfg_data[tlg_pkg::ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    origin_heading <= origin_heading_next;
    if (rst) begin
      step_length <= tlg_pkg::STEP_LENGTH_RST;
      turn_step   <= tlg_pkg::TURN_STEP_RST;
      origin_x    <= tlg_pkg::ORIGIN_X_RST;
      origin_y    <= tlg_pkg::ORIGIN_Y_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tlg_pkg::REG_STEP_LENGTH: step_length <= cfg_data[tlg_pkg::LEN_W-1:0];
        tlg_pkg::REG_TURN_STEP:   turn_step   <= cfg_data[tlg_pkg::ANGLE_W-1:0];
        tlg_pkg::REG_ORIGIN_X:    origin_x    <= cfg_data;
        tlg_pkg::REG_ORIGIN_Y:    origin_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sine tables: one follows the turtle heading, one the origin heading.
  // ---------------------------------------------------------------------------
  assign head_angle = rst ? tlg_pkg::ORIGIN_HEADING_RST : heading_next;

  tlg_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_head_rom (
    .clk  (clk),
    .angle(head_angle),
    .trig (head_trig)
  );

  tlg_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_origin_rom (
    .clk  (clk),
    .angle(origin_heading_next),
    .trig (org_trig)
  );

  // ---------------------------------------------------------------------------
  // Step along the heading: x -= L*sin, y -= L*cos.
  // ---------------------------------------------------------------------------
  tlg_step u_step_x (
    .pen     (base_x),
    .neg     (trig.sin_neg),
    .mag     (trig.sin_mag),
    .len     (step_length),
    .pen_next(step_x)
  );

  tlg_step u_step_y (
    .pen     (base_y),
    .neg     (trig.cos_neg),
    .mag     (trig.cos_mag),
    .len     (step_length),
    .pen_next(step_y)
  );

  tlg_pose_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (stack_ctrl),
    .push_data(push_pose),
    .top      (top_pose),
    .status   (stack_status)
  );

  // ---------------------------------------------------------------------------
  // Action decode and next turtle state.
  // ---------------------------------------------------------------------------
  always_comb begin
    base_x       = restart ? origin_x : pen_x;
    base_y       = restart ? origin_y : pen_y;
    base_heading = restart ? origin_heading : heading;
    trig         = restart ? org_trig : head_trig;
    push_pose    = '{heading: base_heading, y: base_y, x: base_x};

    pen_x_next   = pen_x;
    pen_y_next   = pen_y;
    heading_next = heading;
    stack_ctrl   = '0;
    line_next    = 1'b0;
    fault_next   = tlg_pkg::FAULT_NONE;

    if (accept) begin
      pen_x_next   = base_x;
      pen_y_next   = base_y;
      heading_next = base_heading;
      case (cmd)
        tlg_pkg::CMD_DRAW: begin
          pen_x_next = step_x;
          pen_y_next = step_y;
          line_next  = 1'b1;
        end
        tlg_pkg::CMD_MOVE: begin
          pen_x_next = step_x;
          pen_y_next = step_y;
        end
        tlg_pkg::CMD_CCW: begin
          heading_next = base_heading - turn_step;
        end
        tlg_pkg::CMD_CW: begin
          heading_next = base_heading + turn_step;
        end
        tlg_pkg::CMD_SAVE: begin
          if (stack_status.full) begin
            fault_next = tlg_pkg::FAULT_FULL;
          end else begin
            stack_ctrl.push = 1'b1;
          end
        end
        tlg_pkg::CMD_RESTORE: begin
          if (stack_status.empty) begin
            fault_next = tlg_pkg::FAULT_EMPTY;
          end else begin
            stack_ctrl.pop = 1'b1;
            pen_x_next     = top_pose.x;
            pen_y_next     = top_pose.y;
            heading_next   = top_pose.heading;
          end
        end
        // Stay and the unused code leave the pose after any restart as it is.
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x   <= tlg_pkg::ORIGIN_X_RST;
      pen_y   <= tlg_pkg::ORIGIN_Y_RST;
      heading <= tlg_pkg::ORIGIN_HEADING_RST;
    end else begin
      pen_x   <= pen_x_next;
      pen_y   <= pen_y_next;
      heading <= heading_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. A held result stays while seg_stall is high; a new request
  // loads it in the same cycle the old one leaves.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else begin
      seg_valid <= accept | (seg_valid & seg_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_valid <= line_next;
      from_x     <= line_next ? base_x : '0;
      from_y     <= line_next ? base_y : '0;
      to_x       <= line_next ? step_x : '0;
      to_y       <= line_next ? step_y : '0;
      fault      <= fault_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tlg_checker.sv
// Port-level checks of the turtle line generator and their bind to the top level.
`default_nettype none

module tlg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               act_valid,
  input logic                               act_stall,
  input logic                               seg_valid,
  input logic                               seg_stall,
  input logic                               line_valid,
  input logic signed [tlg_pkg::COORD_W-1:0] from_x,
  input logic signed [tlg_pkg::COORD_W-1:0] from_y,
  input logic signed [tlg_pkg::COORD_W-1:0] to_x,
  input logic signed [tlg_pkg::COORD_W-1:0] to_y,
  input logic [1:0]                         fault
);

  // The result stage is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !seg_valid)
    else $error("result present right after reset");

  // Every accepted request has its result in the cycle after.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (act_valid && !act_stall) |=> seg_valid)
    else $error("accepted request produced no result");

  // A result without a segment carries zero end points, and a faulted one draws nothing.
  a_no_line_zero: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && (!line_valid || fault != tlg_pkg::FAULT_NONE)) |->
      (!line_valid && from_x == '0 && from_y == '0 && to_x == '0 && to_y == '0))
    else $error("segment fields set without a drawn line");

  // A stalled result holds: valid, line_valid, from_x, to_y and fault stay stable.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && seg_stall) |=>
      (seg_valid && $stable(line_valid) && $stable(from_x) && $stable(to_y)
       && $stable(fault)))
    else $error("stalled result changed");

endmodule

bind turtle_line_generator_unit tlg_checker u_tlg_checker (.*);

`default_nettype wire

>>> bench/tb_turtle_line_generator_unit.sv
// Self-checking testbench for the turtle line generator: directed and random requests.
module tb_turtle_line_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // The spare command code is not a named action; the block treats it as a stay.
  localparam logic [2:0] CMD_SPARE = 3'd7;

  localparam int POSE_SLOTS  = 64;
  localparam int TABLE_SIZE  = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 180;

  // Fixed-point constants of the quarter-wave sine series.
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef struct {
    logic [2:0] op;
    logic       again;
  } action_t;

  typedef struct {
    logic                        line_valid;
    logic [tlg_pkg::COORD_W-1:0] from_x;
    logic [tlg_pkg::COORD_W-1:0] from_y;
    logic [tlg_pkg::COORD_W-1:0] to_x;
    logic [tlg_pkg::COORD_W-1:0] to_y;
    logic [1:0]                  fault;
  } segment_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tlg_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          act_valid = 1'b0;
  logic                          act_stall;
  logic [2:0]                    cmd = tlg_pkg::CMD_STAY;
  logic                          restart = 1'b0;
  logic                          seg_valid;
  logic                          seg_stall = 1'b0;
  logic                          line_valid;
  logic [tlg_pkg::COORD_W-1:0]   from_x;
  logic [tlg_pkg::COORD_W-1:0]   from_y;
  logic [tlg_pkg::COORD_W-1:0]   to_x;
  logic [tlg_pkg::COORD_W-1:0]   to_y;
  logic [1:0]                    fault;

  turtle_line_generator_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .act_valid  (act_valid),
    .act_stall  (act_stall),
    .cmd        (cmd),
    .restart    (restart),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .line_valid (line_valid),
    .from_x     (from_x),
    .from_y     (from_y),
    .to_x       (to_x),
    .to_y       (to_y),
    .fault      (fault)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and the segments the turtle is expected to report.
  action_t  pending_actions[$];
  segment_t expected_segments[$];

  // A request is "in flight" from the falling edge that presents it until it is taken.
  int in_flight = 0;
  bit act_took = 1'b0;
  int idle_pct = 22;
  int errors = 0;
  int cycles = 0;

  // Mirror of the configuration registers.
  logic [tlg_pkg::LEN_W-1:0]          len_reg;
  logic [tlg_pkg::ANGLE_W-1:0]        turn_reg;
  logic signed [tlg_pkg::COORD_W-1:0] home_x;
  logic signed [tlg_pkg::COORD_W-1:0] home_y;
  logic [tlg_pkg::ANGLE_W-1:0]        home_heading;

  // Mirror of the turtle: pen, heading and the stack of saved poses.
  int                          pen_x;
  int                          pen_y;
  logic [tlg_pkg::ANGLE_W-1:0] pen_heading;
  int                          saved_x[POSE_SLOTS];
  int                          saved_y[POSE_SLOTS];
  logic [tlg_pkg::ANGLE_W-1:0] saved_heading[POSE_SLOTS];
  int                          stack_fill;

  // Sine and cosine in Q14 for each table index, filled once at time zero.
  int sin_lut[TABLE_SIZE];
  int cos_lut[TABLE_SIZE];

  // Sine over the first quarter turn, evaluated as a truncating Taylor series in Q30
  // and rounded to Q14; num runs from 0 to a full quarter at TABLE_SIZE.
  function automatic int quarter_wave(input int num);
    logic [63:0] x, x2, t, s, r;
    logic [63:0] divisors[5];
    divisors = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    x = (PI_HALF_Q30 * 64'(num)) / 64'(TABLE_SIZE);
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int k = 0; k < 5; k++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / divisors[k];
    end
    s = (x * t) >> 30;
    r = (s + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return int'(r);
  endfunction

  // Full-turn sine on a grid of 4*TABLE_SIZE points, built from the quarter by symmetry.
  function automatic int full_wave(input int u);
    int quad, rem, mag;
    quad = u / TABLE_SIZE;
    rem = u % TABLE_SIZE;
    mag = quad[0] ? quarter_wave(TABLE_SIZE - rem) : quarter_wave(rem);
    return quad[1] ? -mag : mag;
  endfunction

  // Length times a Q14 sine, rounded to Q8 half away from zero.
  function automatic int step_delta(input logic [tlg_pkg::LEN_W-1:0] len, input int s);
    int unsigned mag, d;
    mag = (s < 0) ? -s : s;
    d = (len * mag + 32'd8192) >> 14;
    return (s < 0) ? -int'(d) : int'(d);
  endfunction

  function automatic int clamp24(input int v);
    if (v > 8388607) begin
      return 8388607;
    end
    if (v < -8388608) begin
      return -8388608;
    end
    return v;
  endfunction

  function automatic void home_turtle();
    pen_x = home_x;
    pen_y = home_y;
    pen_heading = home_heading;
  endfunction

  // Applies one request to the mirrored turtle and returns the segment it reports.
  function automatic segment_t advance_turtle(input logic [2:0] op, input logic again);
    segment_t seg;
    int idx, nx, ny;
    seg = '{default: '0};
    if (again) begin
      home_turtle();
    end
    case (op)
      tlg_pkg::CMD_DRAW, tlg_pkg::CMD_MOVE: begin
        idx = (int'(pen_heading) * TABLE_SIZE) >> 16;
        nx = clamp24(pen_x - step_delta(len_reg, sin_lut[idx]));
        ny = clamp24(pen_y - step_delta(len_reg, cos_lut[idx]));
        if (op == tlg_pkg::CMD_DRAW) begin
          seg.line_valid = 1'b1;
          seg.from_x = pen_x[tlg_pkg::COORD_W-1:0];
          seg.from_y = pen_y[tlg_pkg::COORD_W-1:0];
          seg.to_x = nx[tlg_pkg::COORD_W-1:0];
          seg.to_y = ny[tlg_pkg::COORD_W-1:0];
        end
        pen_x = nx;
        pen_y = ny;
      end
      tlg_pkg::CMD_CCW: pen_heading = pen_heading - turn_reg;
      tlg_pkg::CMD_CW: pen_heading = pen_heading + turn_reg;
      tlg_pkg::CMD_SAVE: begin
        if (stack_fill >= POSE_SLOTS) begin
          seg.fault = tlg_pkg::FAULT_FULL;
        end else begin
          saved_x[stack_fill] = pen_x;
          saved_y[stack_fill] = pen_y;
          saved_heading[stack_fill] = pen_heading;
          stack_fill++;
        end
      end
      tlg_pkg::CMD_RESTORE: begin
        if (stack_fill == 0) begin
          seg.fault = tlg_pkg::FAULT_EMPTY;
        end else begin
          stack_fill--;
          pen_x = saved_x[stack_fill];
          pen_y = saved_y[stack_fill];
          pen_heading = saved_heading[stack_fill];
        end
      end
      default: ;
    endcase
    return seg;
  endfunction

  task automatic compare_field(input string name, input logic [tlg_pkg::COORD_W-1:0] want,
                               input logic [tlg_pkg::COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%06h, got 0x%06h", name, want, got);
      errors++;
    end
  endtask

  // Request driver. A presented request stays put until it is taken; only then, or
  // when nothing is presented, is the next one drawn from the queue or an idle cycle
  // inserted. The payload carries junk while valid is low.
  always @(negedge clk) begin : drive_requests
    action_t nxt;
    if (rst) begin
      act_valid <= 1'b0;
    end else if (!act_valid || act_took) begin
      if (pending_actions.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_actions.pop_front();
        in_flight++;
        act_valid <= 1'b1;
        cmd <= nxt.op;
        restart <= nxt.again;
      end else begin
        act_valid <= 1'b0;
        cmd <= 3'($urandom);
        restart <= 1'($urandom);
      end
    end
  end

  // The result side stalls at random, at the same rate as the request side idles.
  always @(negedge clk) begin
    seg_stall <= !rst && ($urandom_range(99) < idle_pct);
  end

  // Monitor. A result at this edge belongs to a request taken at an earlier edge, so
  // it is checked before the request taken at this edge is predicted.
  always @(posedge clk) begin : watch_channels
    segment_t want;
    if (rst) begin
      act_took = 1'b0;
    end else begin
      if (seg_valid && !seg_stall) begin
        if (expected_segments.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_segments.pop_front();
          compare_field("line_valid", tlg_pkg::COORD_W'(want.line_valid),
                        tlg_pkg::COORD_W'(line_valid));
          compare_field("from_x", want.from_x, from_x);
          compare_field("from_y", want.from_y, from_y);
          compare_field("to_x", want.to_x, to_x);
          compare_field("to_y", want.to_y, to_y);
          compare_field("fault", tlg_pkg::COORD_W'(want.fault), tlg_pkg::COORD_W'(fault));
        end
      end
      act_took = act_valid && !act_stall;
      if (act_took) begin
        expected_segments.push_back(advance_turtle(cmd, restart));
        in_flight--;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The mirror follows a register write at once, which is safe because writes only
  // happen while nothing is in flight.
  task automatic write_reg(input logic [tlg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tlg_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      tlg_pkg::REG_STEP_LENGTH: len_reg = data[tlg_pkg::LEN_W-1:0];
      tlg_pkg::REG_TURN_STEP: turn_reg = data[tlg_pkg::ANGLE_W-1:0];
      tlg_pkg::REG_ORIGIN_X: home_x = data;
      tlg_pkg::REG_ORIGIN_Y: home_y = data;
      tlg_pkg::REG_ORIGIN_HEADING: home_heading = data[tlg_pkg::ANGLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Writes all five registers; the unused upper bits of the narrow ones carry junk.
  task automatic configure(input logic [tlg_pkg::LEN_W-1:0] len,
                           input logic [tlg_pkg::ANGLE_W-1:0] turn,
                           input logic [tlg_pkg::COORD_W-1:0] ox,
                           input logic [tlg_pkg::COORD_W-1:0] oy,
                           input logic [tlg_pkg::ANGLE_W-1:0] oh);
    write_reg(tlg_pkg::REG_STEP_LENGTH, {8'($urandom), len});
    write_reg(tlg_pkg::REG_TURN_STEP, {8'($urandom), turn});
    write_reg(tlg_pkg::REG_ORIGIN_X, ox);
    write_reg(tlg_pkg::REG_ORIGIN_Y, oy);
    write_reg(tlg_pkg::REG_ORIGIN_HEADING, {8'($urandom), oh});
  endtask

  task automatic queue_action(input logic [2:0] op, input logic again);
    action_t a;
    a.op = op;
    a.again = again;
    pending_actions.push_back(a);
  endtask

  // Weighted toward drawing and turning, with saves and restores roughly balanced.
  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 30) return tlg_pkg::CMD_DRAW;
    if (r < 40) return tlg_pkg::CMD_MOVE;
    if (r < 52) return tlg_pkg::CMD_CCW;
    if (r < 64) return tlg_pkg::CMD_CW;
    if (r < 76) return tlg_pkg::CMD_SAVE;
    if (r < 88) return tlg_pkg::CMD_RESTORE;
    if (r < 94) return tlg_pkg::CMD_STAY;
    return CMD_SPARE;
  endfunction

  function automatic logic pick_restart();
    return $urandom_range(99) < 4;
  endfunction

  // Branch-heavy walk: pushes far enough to overflow the stack whatever its fill.
  task automatic queue_climb();
    int pushes, goal;
    pushes = 0;
    goal = $urandom_range(72, 66);
    while (pushes < goal) begin
      if ($urandom_range(99) < 70) begin
        queue_action(tlg_pkg::CMD_SAVE, 1'b0);
        pushes++;
      end else begin
        queue_action($urandom_range(1) ? tlg_pkg::CMD_DRAW : tlg_pkg::CMD_CW, 1'b0);
      end
    end
  endtask

  // Walks back out of the branches until the stack runs dry.
  task automatic queue_unwind();
    int pops, goal;
    pops = 0;
    goal = $urandom_range(72, 66);
    while (pops < goal) begin
      if ($urandom_range(99) < 70) begin
        queue_action(tlg_pkg::CMD_RESTORE, 1'b0);
        pops++;
      end else begin
        queue_action($urandom_range(1) ? tlg_pkg::CMD_DRAW : tlg_pkg::CMD_CCW, 1'b0);
      end
    end
  endtask

  // Random traffic made of free mixes and deep save/restore runs.
  task automatic queue_random(input int target);
    int start, r, n;
    start = pending_actions.size();
    while (pending_actions.size() - start < target) begin
      r = $urandom_range(99);
      if (r < 60) begin
        n = $urandom_range(40, 10);
        repeat (n) queue_action(pick_cmd(), pick_restart());
      end else if (r < 80) begin
        queue_climb();
      end else begin
        queue_unwind();
      end
    end
  endtask

  // Holds the sender off until every request has been taken and answered.
  task automatic wait_drained();
    while (pending_actions.size() != 0 || in_flight != 0 || expected_segments.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      sin_lut[i] = full_wave((4 * i) % (4 * TABLE_SIZE));
      cos_lut[i] = full_wave((4 * i + TABLE_SIZE) % (4 * TABLE_SIZE));
    end
    len_reg = tlg_pkg::STEP_LENGTH_RST;
    turn_reg = tlg_pkg::TURN_STEP_RST;
    home_x = tlg_pkg::ORIGIN_X_RST;
    home_y = tlg_pkg::ORIGIN_Y_RST;
    home_heading = tlg_pkg::ORIGIN_HEADING_RST;
    home_turtle();
    stack_fill = 0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed walk at the reset settings: each action, a restore on an empty stack,
    // a save/restore pair, the spare code, and restarts combined with actions.
    queue_action(tlg_pkg::CMD_DRAW, 1'b0);
    queue_action(tlg_pkg::CMD_MOVE, 1'b0);
    queue_action(tlg_pkg::CMD_CW, 1'b0);
    queue_action(tlg_pkg::CMD_DRAW, 1'b0);
    queue_action(tlg_pkg::CMD_CCW, 1'b0);
    queue_action(tlg_pkg::CMD_CCW, 1'b0);
    queue_action(tlg_pkg::CMD_DRAW, 1'b0);
    queue_action(tlg_pkg::CMD_RESTORE, 1'b0);
    queue_action(tlg_pkg::CMD_SAVE, 1'b0);
    queue_action(tlg_pkg::CMD_CW, 1'b0);
    queue_action(tlg_pkg::CMD_DRAW, 1'b0);
    queue_action(tlg_pkg::CMD_RESTORE, 1'b0);
    queue_action(tlg_pkg::CMD_DRAW, 1'b0);
    queue_action(tlg_pkg::CMD_STAY, 1'b0);
    queue_action(CMD_SPARE, 1'b0);
    queue_action(tlg_pkg::CMD_CW, 1'b1);
    queue_action(tlg_pkg::CMD_DRAW, 1'b0);
    queue_action(tlg_pkg::CMD_SAVE, 1'b1);
    queue_action(tlg_pkg::CMD_RESTORE, 1'b0);
    queue_action(tlg_pkg::CMD_RESTORE, 1'b1);
    queue_action(tlg_pkg::CMD_MOVE, 1'b0);
    queue_action(tlg_pkg::CMD_STAY, 1'b1);
    queue_action(tlg_pkg::CMD_DRAW, 1'b0);
    wait_drained();

    // Overflow and then drain the save stack, followed by random traffic.
    queue_climb();
    queue_unwind();
    queue_random(60);
    wait_drained();

    // Longest step, origin at the top corner, heading down: y saturates high.
    configure(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h8000);
    queue_action(tlg_pkg::CMD_DRAW, 1'b1);
    queue_action(tlg_pkg::CMD_DRAW, 1'b0);
    queue_action(tlg_pkg::CMD_CCW, 1'b0);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Zero step and zero turn, origin at the bottom corner: the pen stays put.
    configure(16'h0000, 16'h0000, 24'h800000, 24'h800000, 16'hFFFF);
    queue_action(tlg_pkg::CMD_DRAW, 1'b1);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Heading a quarter turn round with the pen at the low x edge: x saturates low.
    // This stretch runs without idle cycles or stalls.
    configure(16'hFFFF, 16'h4000, 24'h800000, 24'h7FFFFF, 16'h4000);
    idle_pct = 0;
    queue_action(tlg_pkg::CMD_DRAW, 1'b1);
    queue_action(tlg_pkg::CMD_MOVE, 1'b0);
    queue_random(PHASE_ITEMS);
    wait_drained();
    idle_pct = 22;

    repeat (3) begin
      configure(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
      queue_action(tlg_pkg::CMD_DRAW, 1'b1);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (5) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
